// ----- rtl/ecc_pkg.sv -----
// Shared types, codes and constants of the elevator car controller.
package ecc_pkg;

    localparam int FLOORS_DEFAULT      = 5;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // High nibble of a bus address selects the kind of elevator message.
    localparam logic [3:0] ADDR_HALL   = 4'hC;
    localparam logic [3:0] ADDR_CABIN  = 4'hB;
    localparam logic [3:0] ADDR_SENSOR = 4'hE;

    localparam logic FUNC_MSG  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [1:0] SENSOR_FREE   = 2'd0;
    localparam logic [1:0] SENSOR_YELLOW = 2'd1;
    localparam logic [1:0] SENSOR_RED    = 2'd2;
    localparam logic [7:0] SENSOR_MAX    = 8'd2;

    localparam logic [15:0] DWELL_TICKS_RESET = 16'd3000;

    // Register index as seen on the configuration port.
    localparam int         APB_ADDR_W      = 3;
    localparam logic [0:0] REG_DWELL_TICKS = 1'b0;

    typedef logic signed [1:0] dir_t;

    localparam dir_t DIR_DOWN = -2'sd1;
    localparam dir_t DIR_STOP = 2'sd0;
    localparam dir_t DIR_UP   = 2'sd1;

    // Classified item handed from the front end to the car sequencer.
    typedef struct packed {
        logic       is_tick;
        logic       set_call;
        logic       set_sensor;
        logic [1:0] level;
        logic [3:0] floor;
        logic       fwd;
        logic [7:0] fwd_addr;
    } cmd_t;

    // One result item.
    typedef struct packed {
        dir_t       motor_dir;
        logic       door_locked;
        dir_t       shown_direction;
        logic [2:0] shown_floor;
        logic [4:0] call_mask;
        logic       forward_request;
        logic [7:0] forwarded_address;
    } res_t;

endpackage

// ----- rtl/ecc_front.sv -----
// Front end: accepts input items and classifies bus messages and ticks.
module ecc_front
    import ecc_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEFAULT
)
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // address [7:0], value [15:8]
    input  logic        s_tuser,   // func [0]
    input  logic        q_full,
    output logic        push,
    output cmd_t        cmd
);

    logic [7:0] address;
    logic [7:0] value;
    logic [3:0] addr_hi;
    logic [3:0] addr_lo;
    logic       is_msg;
    logic       floor_ok;
    logic       is_elev;
    logic       is_sensor;

    assign address   = s_tdata[7:0];
    assign value     = s_tdata[15:8];
    assign addr_hi   = address[7:4];
    assign addr_lo   = address[3:0];
    assign is_msg    = (s_tuser == FUNC_MSG);
    assign floor_ok  = ({1'b0, addr_lo} < 5'(FLOORS));
    assign is_sensor = (addr_hi == ADDR_SENSOR);
    assign is_elev   = floor_ok &&
                       (addr_hi == ADDR_HALL || addr_hi == ADDR_CABIN || is_sensor);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        cmd.is_tick    = (s_tuser == FUNC_TICK);
        cmd.set_call   = is_msg && is_elev && !is_sensor;
        // A sensor code other than free, yellow or red leaves the sensor alone.
        cmd.set_sensor = is_msg && is_elev && is_sensor && (value <= SENSOR_MAX);
        cmd.level      = value[1:0];
        cmd.floor      = addr_lo;
        cmd.fwd        = is_msg && !is_elev;
        cmd.fwd_addr   = (is_msg && !is_elev) ? address : 8'd0;
    end

endmodule

// ----- rtl/ecc_queue.sv -----
// Short queue of classified items between the front end and the sequencer.
module ecc_queue
    import ecc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic valid
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/ecc_back.sv -----
// Back end: car state machine, call and sensor tables, and the result register.
module ecc_back
    import ecc_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] dwell_ticks,
    input  logic        q_valid,
    input  cmd_t        cmd,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output res_t        res
);

    localparam int IW = $clog2(FLOORS);
    localparam int FW = $clog2(FLOORS + 1);
    localparam logic [FW-1:0]   TOP_FLOOR = FW'(FLOORS);
    localparam logic signed [FW+1:0] DIFF_ONE  = 1;
    localparam logic signed [FW+1:0] DIFF_MONE = -1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PASS_YELLOW,
        PH_PASS_RED,
        PH_PASS_DWELL,
        PH_TGT_YELLOW,
        PH_TGT_RED,
        PH_TGT_DWELL
    } phase_t;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [FW-1:0]        car_floor_reg;
    logic [FW-1:0]        car_floor_next;
    logic [IW-1:0]        target_reg;
    logic [IW-1:0]        target_next;
    dir_t                 travel_dir_reg;
    dir_t                 travel_dir_next;
    logic [FLOORS-1:0]    pending_reg;
    logic [FLOORS-1:0]    pending_next;
    logic [1:0]           sensor_reg [FLOORS];
    logic [1:0]           sensor_next [FLOORS];
    logic [15:0]          dwell_reg;
    logic [15:0]          dwell_next;
    dir_t                 motor_reg;
    dir_t                 motor_next;
    logic                 door_reg;
    logic                 door_next;
    dir_t                 disp_dir_reg;
    dir_t                 disp_dir_next;
    logic [FW-1:0]        disp_floor_reg;
    logic [FW-1:0]        disp_floor_next;
    logic                 out_valid_reg;
    res_t                 out_reg;
    res_t                 out_next;

    logic [IW-1:0]        cmd_idx;
    logic signed [FW:0]   nxt;
    logic                 nxt_in;
    logic [IW-1:0]        nxt_idx;
    logic [1:0]           sens_nxt;
    logic                 call_nxt;
    logic                 car_in;
    logic [IW-1:0]        car_idx;
    logic [FLOORS-1:0]    pend_idle;
    logic                 served;
    logic                 up_hit;
    logic [IW-1:0]        up_idx;
    logic                 dn_hit;
    logic [IW-1:0]        dn_idx;
    logic [IW-1:0]        found_idx;
    dir_t                 found_dir;

    // True when the target lies more than one floor from the car in the travel direction.
    function automatic logic leg_pass(input logic [FW-1:0] car, input logic [IW-1:0] tgt,
                                      input dir_t dir);
        logic signed [FW+1:0] diff;
        diff = signed'({2'b00, FW'(tgt)}) - signed'({2'b00, car});
        return (dir == DIR_UP && diff > DIFF_ONE) || (dir == DIR_DOWN && diff < DIFF_MONE);
    endfunction

    assign pop      = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign res      = out_reg;
    assign cmd_idx  = cmd.floor[IW-1:0];
    assign car_in   = (car_floor_reg < TOP_FLOOR);
    assign car_idx  = car_floor_reg[IW-1:0];

    always_comb
    begin
        // Message or tick takes effect before the state machine looks.
        pending_next = pending_reg;
        sensor_next  = sensor_reg;
        dwell_next   = dwell_reg;
        if (cmd.set_call)
        begin
            pending_next[cmd_idx] = 1'b1;
        end
        if (cmd.set_sensor)
        begin
            sensor_next[cmd_idx] = cmd.level;
        end
        if (cmd.is_tick && dwell_reg != 16'd0)
        begin
            dwell_next = dwell_reg - 16'd1;
        end

        car_floor_next  = car_floor_reg;
        target_next     = target_reg;
        travel_dir_next = travel_dir_reg;
        phase_next      = phase_reg;
        motor_next      = motor_reg;
        door_next       = door_reg;
        disp_dir_next   = disp_dir_reg;
        disp_floor_next = disp_floor_reg;

        // Floor the car approaches next; may fall outside the shaft.
        nxt      = signed'({1'b0, car_floor_reg}) +
                   signed'({{(FW - 1){travel_dir_reg[1]}}, travel_dir_reg});
        nxt_in   = !nxt[FW] && (nxt[FW-1:0] < TOP_FLOOR);
        nxt_idx  = nxt[IW-1:0];
        sens_nxt = nxt_in ? sensor_next[nxt_idx] : SENSOR_FREE;
        call_nxt = nxt_in && pending_next[nxt_idx];

        // Idle search: clear a call at the current floor, then look up, then down.
        pend_idle = pending_next;
        served    = car_in && pending_next[car_idx];
        if (served)
        begin
            pend_idle[car_idx] = 1'b0;
        end
        up_hit = 1'b0;
        up_idx = '0;
        for (int f = FLOORS - 1; f >= 0; f--)
        begin
            if (pend_idle[f] && FW'(f) >= car_floor_reg)
            begin
                up_hit = 1'b1;
                up_idx = IW'(f);
            end
        end
        dn_hit = 1'b0;
        dn_idx = '0;
        for (int f = 0; f < FLOORS; f++)
        begin
            if (pend_idle[f] && FW'(f) < car_floor_reg)
            begin
                dn_hit = 1'b1;
                dn_idx = IW'(f);
            end
        end
        found_idx = up_hit ? up_idx : dn_idx;
        found_dir = up_hit ? DIR_UP : DIR_DOWN;

        unique case (phase_reg)
            PH_IDLE:
            begin
                pending_next = pend_idle;
                if (up_hit || dn_hit)
                begin
                    target_next     = found_idx;
                    travel_dir_next = found_dir;
                    motor_next      = found_dir;
                    disp_dir_next   = found_dir;
                    disp_floor_next = car_floor_reg;
                    door_next       = 1'b1;
                    phase_next      = leg_pass(car_floor_reg, found_idx, found_dir) ?
                                      PH_PASS_YELLOW : PH_TGT_YELLOW;
                end
                else if (served)
                begin
                    door_next = 1'b0;
                end
            end
            PH_PASS_YELLOW:
            begin
                if (sens_nxt == SENSOR_YELLOW)
                begin
                    if (call_nxt)
                    begin
                        motor_next = DIR_STOP;
                    end
                    phase_next = PH_PASS_RED;
                end
            end
            PH_PASS_RED:
            begin
                if (sens_nxt == SENSOR_RED)
                begin
                    if (call_nxt)
                    begin
                        disp_dir_next          = DIR_STOP;
                        disp_floor_next        = nxt[FW-1:0];
                        pending_next[nxt_idx]  = 1'b0;
                        door_next              = 1'b0;
                        dwell_next             = dwell_ticks;
                        phase_next             = PH_PASS_DWELL;
                    end
                    else
                    begin
                        car_floor_next  = nxt[FW-1:0];
                        disp_dir_next   = travel_dir_reg;
                        disp_floor_next = nxt[FW-1:0];
                        phase_next      = leg_pass(nxt[FW-1:0], target_reg, travel_dir_reg) ?
                                          PH_PASS_YELLOW : PH_TGT_YELLOW;
                    end
                end
            end
            PH_PASS_DWELL:
            begin
                if (dwell_next == 16'd0)
                begin
                    door_next       = 1'b1;
                    motor_next      = travel_dir_reg;
                    car_floor_next  = nxt[FW-1:0];
                    disp_dir_next   = travel_dir_reg;
                    disp_floor_next = nxt[FW-1:0];
                    phase_next      = leg_pass(nxt[FW-1:0], target_reg, travel_dir_reg) ?
                                      PH_PASS_YELLOW : PH_TGT_YELLOW;
                end
            end
            PH_TGT_YELLOW:
            begin
                if (sensor_next[target_reg] == SENSOR_YELLOW)
                begin
                    motor_next = DIR_STOP;
                    phase_next = PH_TGT_RED;
                end
            end
            PH_TGT_RED:
            begin
                if (sensor_next[target_reg] == SENSOR_RED)
                begin
                    pending_next[target_reg] = 1'b0;
                    car_floor_next           = FW'(target_reg);
                    disp_dir_next            = DIR_STOP;
                    disp_floor_next          = FW'(target_reg);
                    door_next                = 1'b0;
                    dwell_next               = dwell_ticks;
                    phase_next               = PH_TGT_DWELL;
                end
            end
            PH_TGT_DWELL:
            begin
                if (dwell_next == 16'd0)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        out_next.motor_dir         = motor_next;
        out_next.door_locked       = door_next;
        out_next.shown_direction   = disp_dir_next;
        out_next.shown_floor       = 3'(disp_floor_next);
        out_next.call_mask         = 5'(pending_next);
        out_next.forward_request   = cmd.fwd;
        out_next.forwarded_address = cmd.fwd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            car_floor_reg  <= TOP_FLOOR;
            target_reg     <= '0;
            travel_dir_reg <= DIR_STOP;
            pending_reg    <= FLOORS'(1);
            for (int f = 0; f < FLOORS; f++)
            begin
                sensor_reg[f] <= SENSOR_FREE;
            end
            dwell_reg      <= 16'd0;
            motor_reg      <= DIR_STOP;
            door_reg       <= 1'b0;
            disp_dir_reg   <= DIR_STOP;
            disp_floor_reg <= TOP_FLOOR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                car_floor_reg  <= car_floor_next;
                target_reg     <= target_next;
                travel_dir_reg <= travel_dir_next;
                pending_reg    <= pending_next;
                sensor_reg     <= sensor_next;
                dwell_reg      <= dwell_next;
                motor_reg      <= motor_next;
                door_reg       <= door_next;
                disp_dir_reg   <= disp_dir_next;
                disp_floor_reg <= disp_floor_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- rtl/elevator_car_controller.sv -----
// Top level of the elevator car controller: configuration port, front end, queue, sequencer.
// An accepted item passes through the queue and then the result register.
// Throughput: one item per cycle unless stalled; the queue and result register pass one each.
// A stalled result port holds the result; the queue then fills and input ready drops.
// Reset (rst_n, asynchronous, active low) puts the car above the shaft with a ground-floor
// hall call pending, all sensors released, door open and motor stopped; dwell_ticks is 3000.
module elevator_car_controller
    import ecc_pkg::*;
#(
    parameter int FLOORS      = FLOORS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // address [7:0], value [15:8]
    input  logic                  s_tuser,   // func [0]

    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // motor_dir [1:0], door_locked [2],
                                             // shown_direction [4:3], shown_floor [7:5],
                                             // call_mask [12:8], forwarded_address [20:13]
    output logic                  m_tuser,   // forward_request [0]

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [15:0] dwell_ticks_reg;
    logic        cfg_write;
    logic [0:0]  reg_index;

    logic        q_full;
    logic        q_push;
    cmd_t        q_din;
    logic        q_pop;
    cmd_t        q_dout;
    logic        q_valid;
    res_t        res;

    // The configuration port has a single register, the door dwell time in ticks.
    // Byte address bit 2 selects the register; the low address bits are ignored.
    assign pready    = 1'b1;
    assign reg_index = paddr[2:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_index == REG_DWELL_TICKS) ? {16'd0, dwell_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_ticks_reg <= DWELL_TICKS_RESET;
        end
        else if (cfg_write && reg_index == REG_DWELL_TICKS)
        begin
            dwell_ticks_reg <= pwdata[15:0];
        end
    end

    // The front end decodes bus addresses into calls, sensor updates and
    // forwarding requests, and pushes the classified item into the queue.
    ecc_front #(
        .FLOORS (FLOORS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (q_push),
        .cmd      (q_din)
    );

    // The queue lets the front end keep accepting while a result waits.
    ecc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .valid (q_valid)
    );

    // The sequencer applies each item, lets the car state machine pass at most
    // one wait point, and registers the result.
    ecc_back #(
        .FLOORS (FLOORS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .dwell_ticks (dwell_ticks_reg),
        .q_valid     (q_valid),
        .cmd         (q_dout),
        .pop         (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .res         (res)
    );

    assign m_tdata = {3'd0, res.forwarded_address, res.call_mask, res.shown_floor,
                      res.shown_direction, res.door_locked, res.motor_dir};
    assign m_tuser = res.forward_request;

    // An accepted item is held in the queue on the next cycle.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> q_valid)
        else $error("accepted item did not reach the queue");

    // A result appears only for an item that was waiting in the queue.
    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(q_valid))
        else $error("result produced without a queued item");

    // A waiting item moves to a free result register at once.
    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !m_tvalid) |=> m_tvalid)
        else $error("queued item not moved to the free result register");

    // The forwarded address is zero unless forwarding is requested.
    a_fwd_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser || m_tdata[20:13] == 8'd0))
        else $error("forwarded address set without a forward request");

endmodule
